[hdl/ps2k_pkg.sv]
package ps2k_pkg;

   typedef enum logic [2:0] {
      CMD_SAMPLE      = 3'd0,
      CMD_WRITE       = 3'd1,
      CMD_READ_RX     = 3'd2,
      CMD_READ_STATUS = 3'd3,
      CMD_READ_IRQ    = 3'd4,
      CMD_TICK        = 3'd5
   } cmd_type;

   localparam logic [15:0] HOLD_RESET  = 16'd60;
   localparam logic [7:0]  STATUS_BASE = 8'hC0;
   localparam logic [7:0]  RX_TOP_BIT  = 8'h80;

   localparam logic [3:0] CNT_PARITY = 4'd8;
   localparam logic [3:0] CNT_STOP   = 4'd9;

   typedef struct packed {
      logic [2:0] cmd;
      logic       clock_level;
      logic       data_level;
      logic [7:0] write_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic       drive_data_valid;
      logic       drive_data_level;
      logic       drive_clock_valid;
      logic       drive_clock_level;
      logic       irq_line;
      logic       framing_error;
   } rsp_type;

endpackage

[hdl/ps2k_in_stage.sv]
module ps2k_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ps2k_pkg::req_type req_payload,
   input  logic              step_en,
   output logic              in_valid,
   output ps2k_pkg::req_type in_req
);

   logic              valid_ff;
   logic              valid_in;
   ps2k_pkg::req_type req_ff;
   logic              req_fire;

   assign req_ready = !valid_ff || step_en;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (step_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_payload;
      end
   end

   assign in_valid = valid_ff;
   assign in_req   = req_ff;

endmodule

[hdl/ps2k_core.sv]
module ps2k_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              step_en,
   input  ps2k_pkg::req_type in_req,
   output ps2k_pkg::rsp_type rsp
);

   logic [15:0] hold_ticks_ff;
   logic        last_clock_ff, last_clock_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic        parity_ff, parity_in;
   logic [7:0]  rx_byte_ff, rx_byte_in;
   logic        tx_busy_ff, tx_busy_in;
   logic        hold_active_ff, hold_active_in;
   logic [15:0] hold_left_ff, hold_left_in;
   logic        rx_irq_ff, rx_irq_in;
   logic        fall;

   assign fall = last_clock_ff && !in_req.clock_level && !hold_active_ff;

   always_comb begin
      last_clock_in  = last_clock_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      parity_in      = parity_ff;
      rx_byte_in     = rx_byte_ff;
      tx_busy_in     = tx_busy_ff;
      hold_active_in = hold_active_ff;
      hold_left_in   = hold_left_ff;
      rx_irq_in      = rx_irq_ff;
      rsp            = '0;
      case (in_req.cmd)
         ps2k_pkg::CMD_SAMPLE: begin
            if (fall) begin
               if (tx_busy_ff) begin
                  if (bit_count_ff < ps2k_pkg::CNT_PARITY) begin
                     parity_in             = parity_ff ^ shift_ff[0];
                     rsp.drive_data_valid  = 1'b1;
                     rsp.drive_data_level  = shift_ff[0];
                     shift_in              = {1'b0, shift_ff[7:1]};
                     bit_count_in          = bit_count_ff + 4'd1;
                  end else if (bit_count_ff == ps2k_pkg::CNT_PARITY) begin
                     rsp.drive_data_valid  = 1'b1;
                     rsp.drive_data_level  = !parity_ff;
                     bit_count_in          = bit_count_ff + 4'd1;
                  end else if (bit_count_ff == ps2k_pkg::CNT_STOP) begin
                     rsp.drive_data_valid  = 1'b1;
                     rsp.drive_data_level  = 1'b1;
                     bit_count_in          = bit_count_ff + 4'd1;
                  end else begin
                     tx_busy_in   = 1'b0;
                     bit_count_in = 4'd0;
                     parity_in    = 1'b0;
                  end
               end else begin
                  if (bit_count_ff == 4'd0) begin
                     rsp.framing_error = in_req.data_level;
                     bit_count_in      = 4'd1;
                  end else if (bit_count_ff <= ps2k_pkg::CNT_PARITY) begin
                     shift_in     = {in_req.data_level, shift_ff[7:1]};
                     bit_count_in = bit_count_ff + 4'd1;
                  end else if (bit_count_ff == ps2k_pkg::CNT_STOP) begin
                     bit_count_in = bit_count_ff + 4'd1;
                  end else begin
                     rsp.framing_error     = !in_req.data_level;
                     bit_count_in          = 4'd0;
                     rx_byte_in            = shift_ff;
                     rx_irq_in             = 1'b1;
                     rsp.drive_clock_valid = 1'b1;
                  end
               end
            end
            last_clock_in = in_req.clock_level;
         end
         ps2k_pkg::CMD_WRITE: begin
            tx_busy_in            = 1'b1;
            shift_in              = in_req.write_byte;
            hold_active_in        = 1'b1;
            hold_left_in          = hold_ticks_ff;
            rsp.drive_clock_valid = 1'b1;
         end
         ps2k_pkg::CMD_READ_RX: begin
            rsp.read_value        = rx_byte_ff;
            rsp.drive_clock_valid = 1'b1;
            rsp.drive_clock_level = 1'b1;
         end
         ps2k_pkg::CMD_READ_STATUS: begin
            rsp.read_value = ps2k_pkg::STATUS_BASE | {5'd0, tx_busy_ff, 2'd0};
         end
         ps2k_pkg::CMD_READ_IRQ: begin
            rsp.read_value = {2'd0, rx_irq_ff, 5'd0};
            rx_irq_in      = 1'b0;
         end
         ps2k_pkg::CMD_TICK: begin
            if (hold_active_ff) begin
               if (hold_left_ff <= 16'd1) begin
                  hold_left_in          = 16'd0;
                  hold_active_in        = 1'b0;
                  rsp.drive_data_valid  = 1'b1;
                  rsp.drive_clock_valid = 1'b1;
                  rsp.drive_clock_level = 1'b1;
               end else begin
                  hold_left_in = hold_left_ff - 16'd1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp.irq_line = rx_irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= ps2k_pkg::HOLD_RESET;
      end else if (csr_we) begin
         hold_ticks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clock_ff  <= 1'b0;
         bit_count_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         parity_ff      <= 1'b0;
         rx_byte_ff     <= 8'd0;
         tx_busy_ff     <= 1'b0;
         hold_active_ff <= 1'b0;
         hold_left_ff   <= 16'd0;
         rx_irq_ff      <= 1'b0;
      end else if (step_en) begin
         last_clock_ff  <= last_clock_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         parity_ff      <= parity_in;
         rx_byte_ff     <= rx_byte_in;
         tx_busy_ff     <= tx_busy_in;
         hold_active_ff <= hold_active_in;
         hold_left_ff   <= hold_left_in;
         rx_irq_ff      <= rx_irq_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= 4'd10)
      else $error("bit count beyond stop");

   a_hold_end: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(hold_active_ff) |->
         $past(step_en) && $past(in_req.cmd) == ps2k_pkg::CMD_TICK)
      else $error("hold ended without a tick");

   a_irq_raise: assert property (@(posedge clock) disable iff (reset)
      $rose(rx_irq_ff) |->
         $past(step_en) && $past(in_req.cmd) == ps2k_pkg::CMD_SAMPLE)
      else $error("irq raised outside a line sample");

   a_busy_raise: assert property (@(posedge clock) disable iff (reset)
      $rose(tx_busy_ff) |->
         $past(step_en) && $past(in_req.cmd) == ps2k_pkg::CMD_WRITE
         && hold_active_ff)
      else $error("busy set without a host write");

endmodule

[hdl/ps2k_rsp_stage.sv]
module ps2k_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ps2k_pkg::rsp_type rsp,
   output logic              step_en,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ps2k_pkg::rsp_type rsp_payload
);

   logic              valid_ff;
   logic              valid_in;
   ps2k_pkg::rsp_type rsp_ff;

   assign step_en = in_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (step_en) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/ps2_host_keyboard_interface.sv]
// Host side of a PS/2 keyboard link, driven by a stream of requests.
// Request channel (req_valid/req_ready/req_payload): each request is a line
// sample, a host write, a read of rx byte, status or irq status, or a tick.
// Response channel (rsp_valid/rsp_ready/rsp_payload): exactly one response
// per request, in order, carrying read data, line drive changes, the irq
// level and a framing error flag.
// A request accepted into the input register is processed by the core and
// its response registered once the response register is free or taken.
// Throughput: one request per cycle while rsp_ready is high; the input
// and response registers let a new request enter while a response waits.
// When rsp_ready is low the response register holds, the input register
// fills, and req_ready drops until the response is taken.
// csr_we/csr_wdata write hold_ticks (ticks the clock is held low after a
// host write); write it only while no request is in flight.
// Reset (synchronous, active high) empties both registers, clears the link
// state and sets hold_ticks to 60.
module ps2_host_keyboard_interface (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ps2k_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ps2k_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   logic              in_valid;
   logic              step_en;
   ps2k_pkg::req_type in_req;
   ps2k_pkg::rsp_type rsp;

   ps2k_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .step_en     (step_en),
      .in_valid    (in_valid),
      .in_req      (in_req)
   );

   ps2k_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step_en   (step_en),
      .in_req    (in_req),
      .rsp       (rsp)
   );

   ps2k_rsp_stage u_rsp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid),
      .rsp         (rsp),
      .step_en     (step_en),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[bench/ps2_host_keyboard_interface_test.sv]
module ps2_host_keyboard_interface_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0]  CMD_SPARE_A = 3'd6;
   localparam logic [2:0]  CMD_SPARE_B = 3'd7;
   localparam int unsigned FRAME_EDGES = 11;
   localparam int unsigned SCRIPT_ROWS = 25;
   localparam int unsigned PHASE_ITEMS = 250;
   localparam int unsigned QUIET_LIMIT = 3000;

   typedef enum bit {ROW_SINGLE, ROW_FRAME} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [2:0]        cmd;
      bit                lvl_a;
      bit                lvl_b;
      logic [7:0]        data;
      int unsigned       reps;
      bit                known;
      ps2k_pkg::rsp_type known_rsp;
   } script_row_type;

   typedef struct {
      ps2k_pkg::req_type req;
      bit                known;
      ps2k_pkg::rsp_type known_rsp;
   } planned_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ps2k_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ps2k_pkg::rsp_type rsp_payload;
   logic              csr_we = 1'b0;
   logic [15:0]       csr_wdata = '0;

   // link model state
   logic        prev_clk = 1'b0;
   logic [3:0]  frame_pos = '0;
   logic [7:0]  shifter = '0;
   logic        parity_bit = 1'b0;
   logic [7:0]  latched_byte = '0;
   logic        sending = 1'b0;
   logic        holding = 1'b0;
   logic [15:0] hold_count = '0;
   logic        irq_pending = 1'b0;
   logic [15:0] hold_setting = ps2k_pkg::HOLD_RESET;

   ps2k_pkg::rsp_type predicted_rsp[$];
   planned_type       request_plan[$];
   script_row_type    script_rows [SCRIPT_ROWS];
   int unsigned       send_idle;
   int unsigned       recv_idle;
   int unsigned       phase_items;
   int unsigned       mismatches = 0;

   ps2_host_keyboard_interface dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic ps2_link_step(input ps2k_pkg::req_type r, output ps2k_pkg::rsp_type o);
      o = '0;
      case (r.cmd)
         ps2k_pkg::CMD_SAMPLE: begin
            if (prev_clk && !r.clock_level && !holding) begin
               if (sending) begin
                  if (frame_pos < ps2k_pkg::CNT_PARITY) begin
                     o.drive_data_valid = 1'b1;
                     o.drive_data_level = shifter[0];
                     parity_bit = parity_bit ^ shifter[0];
                     shifter = shifter >> 1;
                     frame_pos = frame_pos + 4'd1;
                  end else if (frame_pos == ps2k_pkg::CNT_PARITY) begin
                     o.drive_data_valid = 1'b1;
                     o.drive_data_level = ~parity_bit;
                     frame_pos = frame_pos + 4'd1;
                  end else if (frame_pos == ps2k_pkg::CNT_STOP) begin
                     o.drive_data_valid = 1'b1;
                     o.drive_data_level = 1'b1;
                     frame_pos = frame_pos + 4'd1;
                  end else begin
                     sending = 1'b0;
                     frame_pos = '0;
                     parity_bit = 1'b0;
                  end
               end else begin
                  if (frame_pos == 4'd0) begin
                     o.framing_error = r.data_level;
                     frame_pos = 4'd1;
                  end else if (frame_pos <= ps2k_pkg::CNT_PARITY) begin
                     shifter = (shifter >> 1) |
                               (r.data_level ? ps2k_pkg::RX_TOP_BIT : 8'h00);
                     frame_pos = frame_pos + 4'd1;
                  end else if (frame_pos == ps2k_pkg::CNT_STOP) begin
                     frame_pos = frame_pos + 4'd1;
                  end else begin
                     o.framing_error = ~r.data_level;
                     frame_pos = '0;
                     latched_byte = shifter;
                     irq_pending = 1'b1;
                     o.drive_clock_valid = 1'b1;
                     o.drive_clock_level = 1'b0;
                  end
               end
            end
            prev_clk = r.clock_level;
         end
         ps2k_pkg::CMD_WRITE: begin
            sending = 1'b1;
            shifter = r.write_byte;
            holding = 1'b1;
            hold_count = hold_setting;
            o.drive_clock_valid = 1'b1;
            o.drive_clock_level = 1'b0;
         end
         ps2k_pkg::CMD_READ_RX: begin
            o.read_value = latched_byte;
            o.drive_clock_valid = 1'b1;
            o.drive_clock_level = 1'b1;
         end
         ps2k_pkg::CMD_READ_STATUS: begin
            o.read_value = ps2k_pkg::STATUS_BASE | {5'd0, sending, 2'd0};
         end
         ps2k_pkg::CMD_READ_IRQ: begin
            o.read_value = {2'd0, irq_pending, 5'd0};
            irq_pending = 1'b0;
         end
         ps2k_pkg::CMD_TICK: begin
            if (holding) begin
               if (hold_count <= 16'd1) begin
                  hold_count = '0;
                  holding = 1'b0;
                  o.drive_data_valid = 1'b1;
                  o.drive_data_level = 1'b0;
                  o.drive_clock_valid = 1'b1;
                  o.drive_clock_level = 1'b1;
               end else begin
                  hold_count = hold_count - 16'd1;
               end
            end
         end
         default: ;
      endcase
      o.irq_line = irq_pending;
   endtask

   function automatic script_row_type single_row(logic [2:0] c, bit clk, bit dat,
                                                 logic [7:0] b, int unsigned n);
      script_row_type r;
      r.kind = ROW_SINGLE;
      r.cmd = c;
      r.lvl_a = clk;
      r.lvl_b = dat;
      r.data = b;
      r.reps = n;
      r.known = 1'b0;
      r.known_rsp = '0;
      return r;
   endfunction

   // reads and no-ops whose response is plain: read value and clock release only
   function automatic script_row_type pinned_row(logic [2:0] c, logic [7:0] rv, bit rel);
      script_row_type r;
      r = single_row(c, 1'b0, 1'b0, 8'h00, 1);
      r.known = 1'b1;
      r.known_rsp.read_value = rv;
      r.known_rsp.drive_clock_valid = rel;
      r.known_rsp.drive_clock_level = rel;
      return r;
   endfunction

   function automatic script_row_type frame_row(bit start, logic [7:0] b, bit stop,
                                                int unsigned n);
      script_row_type r;
      r = single_row(ps2k_pkg::CMD_SAMPLE, start, stop, b, n);
      r.kind = ROW_FRAME;
      return r;
   endfunction

   function automatic bit frame_level(int unsigned i, bit start, logic [7:0] b, bit par,
                                      bit stop);
      if (i == 0) return start;
      if (i <= 8) return b[i-1];
      if (i == 9) return par;
      return stop;
   endfunction

   task automatic push_entry(logic [2:0] c, bit clk, bit dat, logic [7:0] b, bit known,
                             ps2k_pkg::rsp_type want);
      planned_type p;
      p.req.cmd = c;
      p.req.clock_level = clk;
      p.req.data_level = dat;
      p.req.write_byte = b;
      p.known = known;
      p.known_rsp = want;
      request_plan.push_back(p);
   endtask

   task automatic push_req(logic [2:0] c, bit clk, bit dat, logic [7:0] b);
      push_entry(c, clk, dat, b, 1'b0, '0);
   endtask

   task automatic push_random(logic [2:0] c);
      push_req(c, 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   // one falling edge, sometimes with a harmless request while the line is high
   task automatic add_edge(bit lvl);
      push_req(ps2k_pkg::CMD_SAMPLE, 1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
      if ($urandom_range(6) == 0) begin
         case ($urandom_range(2))
            0: push_random(ps2k_pkg::CMD_READ_STATUS);
            1: push_random(CMD_SPARE_B);
            default: push_req(ps2k_pkg::CMD_SAMPLE, 1'b1, 1'($urandom_range(1)),
                              8'($urandom_range(255)));
         endcase
      end
      push_req(ps2k_pkg::CMD_SAMPLE, 1'b0, lvl, 8'($urandom_range(255)));
   endtask

   task automatic add_frame(bit start, logic [7:0] b, bit par, bit stop, int unsigned n);
      for (int unsigned i = 0; i < n; i++) add_edge(frame_level(i, start, b, par, stop));
   endtask

   // end any hold and run any frame in progress to its end
   task automatic settle_link();
      if (holding)
         repeat ((hold_count > 16'd1) ? hold_count : 16'd1) push_random(ps2k_pkg::CMD_TICK);
      if (holding || sending || frame_pos != 4'd0)
         repeat (FRAME_EDGES - frame_pos) add_edge(1'b1);
   endtask

   task automatic plan_rx_frame();
      settle_link();
      add_frame($urandom_range(9) == 0, 8'($urandom_range(255)), 1'($urandom_range(1)),
                $urandom_range(9) != 0, FRAME_EDGES);
      case ($urandom_range(2))
         0: begin
            push_random(ps2k_pkg::CMD_READ_IRQ);
            push_random(ps2k_pkg::CMD_READ_RX);
         end
         1: begin
            push_random(ps2k_pkg::CMD_READ_RX);
            push_random(ps2k_pkg::CMD_READ_IRQ);
         end
         default: ;
      endcase
   endtask

   task automatic plan_tx();
      if ($urandom_range(3) != 0) settle_link();
      push_random(ps2k_pkg::CMD_WRITE);
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 3)) push_random(ps2k_pkg::CMD_TICK);
         push_random(ps2k_pkg::CMD_WRITE);
      end
      repeat ((hold_setting > 16'd1) ? hold_setting : 16'd1) begin
         if ($urandom_range(9) == 0) push_random(ps2k_pkg::CMD_READ_STATUS);
         if ($urandom_range(19) == 0) add_edge(1'($urandom_range(1)));
         push_random(ps2k_pkg::CMD_TICK);
      end
      repeat (FRAME_EDGES) add_edge(1'($urandom_range(1)));
      push_random(ps2k_pkg::CMD_READ_STATUS);
   endtask

   task automatic plan_broken();
      settle_link();
      add_frame(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)), $urandom_range(1, 10));
      case ($urandom_range(3))
         0: push_random(ps2k_pkg::CMD_WRITE);
         1: push_random(ps2k_pkg::CMD_READ_RX);
         2: push_random(ps2k_pkg::CMD_READ_IRQ);
         default: ;
      endcase
   endtask

   task automatic plan_sequence();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35) plan_rx_frame();
      else if (pick < 65) plan_tx();
      else if (pick < 80) plan_broken();
      else repeat ($urandom_range(1, 6)) push_random(3'($urandom_range(7)));
   endtask

   task automatic send_request(planned_type p);
      ps2k_pkg::rsp_type got;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p.req;
      do @(posedge clock); while (!req_ready);
      ps2_link_step(p.req, got);
      predicted_rsp.push_back(p.known ? p.known_rsp : got);
      phase_items++;
   endtask

   task automatic run_plan();
      while (request_plan.size() != 0) send_request(request_plan.pop_front());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_hold(logic [15:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      hold_setting = v;
   endtask

   always @(posedge clock) begin : check_responses
      ps2k_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp.size() == 0) begin
            $display("%0t: expected nothing actual %h", $time, rsp_payload);
            mismatches++;
         end else begin
            want = predicted_rsp.pop_front();
            if (want !== rsp_payload) begin
               $display("%0t: expected %h actual %h", $time, want, rsp_payload);
               mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      do begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end while (quiet < QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] phase_holds [6];
      phase_holds = '{16'd1, 16'd0, 16'd60, 16'd2, 16'd9, 16'd1};
      send_idle = 23;
      recv_idle = 51;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      script_rows = '{
         pinned_row(ps2k_pkg::CMD_READ_STATUS, ps2k_pkg::STATUS_BASE, 1'b0),
         pinned_row(ps2k_pkg::CMD_READ_IRQ, 8'h00, 1'b0),
         pinned_row(ps2k_pkg::CMD_READ_RX, 8'h00, 1'b1),
         pinned_row(CMD_SPARE_A, 8'h00, 1'b0),
         pinned_row(CMD_SPARE_B, 8'h00, 1'b0),
         pinned_row(ps2k_pkg::CMD_TICK, 8'h00, 1'b0),
         frame_row(1'b1, 8'hFF, 1'b0, FRAME_EDGES),
         single_row(ps2k_pkg::CMD_READ_RX, 1'b0, 1'b0, 8'h00, 1),
         pinned_row(ps2k_pkg::CMD_READ_IRQ, 8'h20, 1'b0),
         frame_row(1'b0, 8'h00, 1'b1, FRAME_EDGES),
         single_row(ps2k_pkg::CMD_READ_IRQ, 1'b1, 1'b1, 8'hFF, 1),
         single_row(ps2k_pkg::CMD_READ_RX, 1'b0, 1'b0, 8'h00, 1),
         single_row(ps2k_pkg::CMD_WRITE, 1'b0, 1'b0, 8'hFF, 1),
         frame_row(1'b0, 8'h55, 1'b1, 3),
         single_row(ps2k_pkg::CMD_TICK, 1'b0, 1'b0, 8'h00, 30),
         single_row(ps2k_pkg::CMD_WRITE, 1'b1, 1'b1, 8'h00, 1),
         single_row(ps2k_pkg::CMD_TICK, 1'b0, 1'b0, 8'h00, 59),
         pinned_row(ps2k_pkg::CMD_READ_STATUS, ps2k_pkg::STATUS_BASE | 8'h04, 1'b0),
         single_row(ps2k_pkg::CMD_TICK, 1'b0, 1'b0, 8'h00, 1),
         frame_row(1'b0, 8'hAA, 1'b1, FRAME_EDGES),
         pinned_row(ps2k_pkg::CMD_READ_STATUS, ps2k_pkg::STATUS_BASE, 1'b0),
         frame_row(1'b0, 8'h5A, 1'b1, 4),
         single_row(ps2k_pkg::CMD_WRITE, 1'b0, 1'b0, 8'h81, 1),
         single_row(ps2k_pkg::CMD_TICK, 1'b0, 1'b0, 8'h00, 60),
         frame_row(1'b1, 8'h3C, 1'b0, FRAME_EDGES)
      };
      for (int unsigned i = 0; i < SCRIPT_ROWS; i++) begin
         if (script_rows[i].kind == ROW_FRAME)
            add_frame(script_rows[i].lvl_a, script_rows[i].data, 1'b1,
                      script_rows[i].lvl_b, script_rows[i].reps);
         else
            repeat (script_rows[i].reps)
               push_entry(script_rows[i].cmd, script_rows[i].lvl_a, script_rows[i].lvl_b,
                          script_rows[i].data, script_rows[i].known,
                          script_rows[i].known_rsp);
      end
      run_plan();

      for (int p = 0; p < 6; p++) begin
         set_hold(phase_holds[p]);
         case (p / 2)
            0: begin
               send_idle = 23;
               recv_idle = 51;
            end
            1: begin
               send_idle = 51;
               recv_idle = 23;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            plan_sequence();
            run_plan();
         end
      end

      // widest hold setting; a later write inside that hold restarts it from a short one
      set_hold(16'hFFFF);
      settle_link();
      push_random(ps2k_pkg::CMD_WRITE);
      add_edge(1'b0);
      repeat (3) push_random(ps2k_pkg::CMD_TICK);
      push_random(ps2k_pkg::CMD_READ_STATUS);
      run_plan();
      set_hold(16'd3);
      push_random(ps2k_pkg::CMD_WRITE);
      repeat (3) push_random(ps2k_pkg::CMD_TICK);
      repeat (FRAME_EDGES) add_edge(1'($urandom_range(1)));
      push_random(ps2k_pkg::CMD_READ_STATUS);
      run_plan();

      drain();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
